// ----- rtl/core/smo_pll_pkg.sv -----
// ----------------------------------------------------------------------------
// smo_pll_pkg
// Shared constants, widths and helpers for the sliding-mode observer PLL.
// ----------------------------------------------------------------------------
package smo_pll_pkg;

  // Default table and angle resolution
  localparam int SineTableBitsDef = 10;
  localparam int AngleBitsDef     = 16;

  // Serial multiplier operand and product widths
  localparam int MulAW   = 50;
  localparam int MulBW   = 33;
  localparam int MulPW   = MulAW + MulBW;
  localparam int MulCntW = $clog2(MulBW + 1);

  // Register reset values
  localparam logic [31:0] SamplePeriodRst = 32'd214748;
  localparam logic [15:0] SlideGainRst    = 16'd3072;
  localparam logic [31:0] PropGainRst     = 32'd65536;
  localparam logic [31:0] IntGainRst      = 32'd65536;

  // Fixed-point constants
  localparam longint C1 = 64'sd1686629713;
  localparam longint C3 = -64'sd693598668;
  localparam longint C5 = 64'sd85569306;
  localparam longint C7 = -64'sd5026995;
  localparam longint C9 = 64'sd172272;
  localparam longint Lim47 = 64'sd140737488355328;
  localparam logic [31:0] InvTwoPiQ32 = 32'd683565276;

  // Configuration register indexes
  typedef enum logic [7:0] {
    REG_SAMPLE_PERIOD = 8'd0,
    REG_SLIDE_GAIN    = 8'd1,
    REG_PLL_PROP_GAIN = 8'd2,
    REG_PLL_INT_GAIN  = 8'd3
  } cfg_reg_e;

  // Saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) r = 32'sh7fffffff;
    else if (x < -64'sd2147483648) r = 32'sh80000000;
    else r = 32'(x);
    return r;
  endfunction

  // Clamp to +-2^47 and size for the multiplier
  function automatic logic signed [MulAW-1:0] clamp47(input logic signed [63:0] x);
    logic signed [63:0] r;
    if (x > Lim47) r = Lim47;
    else if (x < -Lim47) r = -Lim47;
    else r = x;
    return MulAW'(r);
  endfunction

  // One quarter-wave sine entry from a Q30 fraction of the quarter
  function automatic logic signed [15:0] quarter_sine(input longint u);
    longint u2;
    longint acc;
    longint s;
    u2  = (u * u) >>> 30;
    acc = C9;
    acc = C7 + ((acc * u2) >>> 30);
    acc = C5 + ((acc * u2) >>> 30);
    acc = C3 + ((acc * u2) >>> 30);
    acc = C1 + ((acc * u2) >>> 30);
    s   = (acc * u) >>> 30;
    s   = (s + 64'sd16384) >>> 15;
    if (s < 0) s = 0;
    if (s > 32767) s = 32767;
    return 16'(s);
  endfunction

endpackage

// ----- rtl/core/smo_pll_mul.sv -----
// ----------------------------------------------------------------------------
// smo_pll_mul
// Bit-serial signed multiplier: one bit of the B operand per cycle.
// ----------------------------------------------------------------------------
module smo_pll_mul (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [smo_pll_pkg::MulAW-1:0]  a_i,
  input  logic signed [smo_pll_pkg::MulBW-1:0]  b_i,
  output logic                                  done_o,
  output logic signed [smo_pll_pkg::MulPW-1:0]  prod_o
);

  logic                                 busy_q;
  logic                                 done_q;
  logic [smo_pll_pkg::MulCntW-1:0]      cnt_q;
  logic signed [smo_pll_pkg::MulPW-1:0] a_q;
  logic signed [smo_pll_pkg::MulPW-1:0] acc_q;
  logic signed [smo_pll_pkg::MulBW-1:0] b_q;
  logic                                 last;

  assign last = (cnt_q == smo_pll_pkg::MulCntW'(smo_pll_pkg::MulBW - 1));

  // Shift-add over B; the top bit of B carries negative weight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
      acc_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        a_q    <= smo_pll_pkg::MulPW'(a_i);
        b_q    <= b_i;
        acc_q  <= '0;
      end else if (busy_q) begin
        if (b_q[0]) begin
          acc_q <= last ? (acc_q - a_q) : (acc_q + a_q);
        end
        a_q   <= a_q <<< 1;
        b_q   <= b_q >>> 1;
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ----- rtl/core/sliding_mode_observer_pll.sv -----
// ----------------------------------------------------------------------------
// sliding_mode_observer_pll
// Sensorless angle and speed estimator: sliding-mode back-EMF observer + PLL.
// ----------------------------------------------------------------------------
// One item per control period: alpha/beta currents and the q-axis voltage go
// in, the estimated angle, filtered speed and filtered back-EMF come out. All
// products run one after another through a single bit-serial multiplier, one
// bit per cycle, 23 products per item, and the next item is only accepted once
// the current result is loaded. The result sits in an output register,
// so the next item is taken while it waits. Configuration is taken at any
// time on its own channel and is meant to be written between items.
module sliding_mode_observer_pll #(
  parameter int SINE_TABLE_BITS = smo_pll_pkg::SineTableBitsDef,
  parameter int ANGLE_BITS      = smo_pll_pkg::AngleBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] meas_i_alpha, [31:16] meas_i_beta, [47:32] volt_q_cmd
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] angle_est, [47:16] speed_est_filt, [63:48] emf_alpha_filt,
  // [79:64] emf_beta_filt
  output logic [79:0] m_axis_tdata
);

  localparam int RomSize    = 1 << SINE_TABLE_BITS;
  localparam int RomQuarter = RomSize / 4;
  localparam int AW = smo_pll_pkg::MulAW;
  localparam int BW = smo_pll_pkg::MulBW;
  localparam int PW = smo_pll_pkg::MulPW;

  typedef logic signed [15:0] rom_t [RomSize];

  // Build the sine table at elaboration
  function automatic rom_t build_rom();
    rom_t r;
    int   q;
    int   quad;
    int   j;
    logic signed [15:0] v;
    q = RomQuarter;
    for (int k = 0; k < RomSize; k++) begin
      quad = (k >> (SINE_TABLE_BITS - 2)) & 3;
      j    = k & (q - 1);
      if (quad[0]) j = q - j;
      v = smo_pll_pkg::quarter_sine(longint'(j) * (longint'(1) << (32 - SINE_TABLE_BITS)));
      r[k] = (quad >= 2) ? -v : v;
    end
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_DONE} state_e;

  typedef enum logic [4:0] {
    OP_SIN_UQ, OP_COS_UQ,
    OP_OBS_A, OP_DIF_A, OP_INT_A, OP_EMF_A,
    OP_OBS_B, OP_DIF_B, OP_INT_B, OP_EMF_B,
    OP_LPO_A, OP_LPN_A, OP_LPO_B, OP_LPN_B,
    OP_ERR_C, OP_ERR_S, OP_KI, OP_TS_I, OP_KP,
    OP_SPO, OP_SPN, OP_RAD, OP_ANG
  } op_e;

  // Configuration registers
  logic [31:0] ts_q, kp_q, ki_q;
  logic [15:0] h_q;

  // Observer and PLL state
  logic signed [31:0] obs_a_q, obs_b_q, emf_a_q, emf_b_q, lp_a_q, lp_b_q;
  logic signed [31:0] integ_q, speed_lp_q, speed_q, ua_q, ub_q;
  logic signed [33:0] err_q;
  logic signed [63:0] tmp_q;
  logic [31:0]        angle_q;

  // Item and sequencing
  logic signed [15:0] ia_q, ib_q, uq_q;
  state_e             state_q;
  op_e                op_q;
  logic               out_valid_q;
  logic [79:0]        out_data_q;

  // Multiplier hookup
  logic                 mul_start, mul_done;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [63:0]   p_s32, p_s16;

  // Table lookup at the held angle
  logic [SINE_TABLE_BITS-1:0] sidx, cidx;
  logic signed [15:0]         sin_q, cos_q;

  assign sidx = angle_q[31 -: SINE_TABLE_BITS];
  assign cidx = sidx + SINE_TABLE_BITS'(RomQuarter);

  // Register the table reads; the angle only moves at the end of an item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sin_q <= '0;
      cos_q <= '0;
    end else begin
      sin_q <= SineRom[sidx];
      cos_q <= SineRom[cidx];
    end
  end

  // Saturated current error, 0.5 A limit
  logic signed [35:0] ea_w, eb_w;
  logic signed [17:0] ra_w, rb_w;

  always_comb begin
    ea_w = 36'(obs_a_q) - (36'(ia_q) <<< 6);
    eb_w = 36'(obs_b_q) - (36'(ib_q) <<< 6);
    ea_w = ea_w <<< 1;
    eb_w = eb_w <<< 1;
    if (ea_w > 36'sd65536) ra_w = 18'sd65536;
    else if (ea_w < -36'sd65536) ra_w = -18'sd65536;
    else ra_w = 18'(ea_w);
    if (eb_w > 36'sd65536) rb_w = 18'sd65536;
    else if (eb_w < -36'sd65536) rb_w = -18'sd65536;
    else rb_w = 18'(eb_w);
  end

  // Select the operands of the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op_q)
      OP_SIN_UQ: begin mul_a = AW'(sin_q); mul_b = BW'(uq_q); end
      OP_COS_UQ: begin mul_a = AW'(cos_q); mul_b = BW'(uq_q); end
      OP_OBS_A:  begin mul_a = AW'(obs_a_q); mul_b = -BW'(500); end
      OP_DIF_A:  begin mul_a = AW'(ua_q) - AW'(emf_a_q); mul_b = BW'(1250); end
      OP_INT_A:  begin mul_a = smo_pll_pkg::clamp47(tmp_q); mul_b = {1'b0, ts_q}; end
      OP_EMF_A:  begin mul_a = AW'(ra_w); mul_b = BW'({1'b0, h_q}); end
      OP_OBS_B:  begin mul_a = AW'(obs_b_q); mul_b = -BW'(500); end
      OP_DIF_B:  begin mul_a = AW'(ub_q) - AW'(emf_b_q); mul_b = BW'(1250); end
      OP_INT_B:  begin mul_a = smo_pll_pkg::clamp47(tmp_q); mul_b = {1'b0, ts_q}; end
      OP_EMF_B:  begin mul_a = AW'(rb_w); mul_b = BW'({1'b0, h_q}); end
      OP_LPO_A:  begin mul_a = AW'(lp_a_q); mul_b = BW'(6554); end
      OP_LPN_A:  begin mul_a = AW'(emf_a_q); mul_b = BW'(58982); end
      OP_LPO_B:  begin mul_a = AW'(lp_b_q); mul_b = BW'(6554); end
      OP_LPN_B:  begin mul_a = AW'(emf_b_q); mul_b = BW'(58982); end
      OP_ERR_C:  begin mul_a = AW'(emf_a_q); mul_b = BW'(cos_q); end
      OP_ERR_S:  begin mul_a = AW'(emf_b_q); mul_b = BW'(sin_q); end
      OP_KI:     begin mul_a = AW'(err_q); mul_b = {1'b0, ki_q}; end
      OP_TS_I:   begin mul_a = smo_pll_pkg::clamp47(tmp_q); mul_b = {1'b0, ts_q}; end
      OP_KP:     begin mul_a = AW'(err_q); mul_b = {1'b0, kp_q}; end
      OP_SPO:    begin mul_a = AW'(speed_lp_q); mul_b = BW'(58982); end
      OP_SPN:    begin mul_a = AW'(speed_q); mul_b = BW'(6554); end
      OP_RAD:    begin
        mul_a = smo_pll_pkg::clamp47(64'(speed_lp_q) <<< 16);
        mul_b = {1'b0, ts_q};
      end
      OP_ANG:    begin
        mul_a = smo_pll_pkg::clamp47(tmp_q);
        mul_b = {1'b0, smo_pll_pkg::InvTwoPiQ32};
      end
      default:   begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_start = (state_q == ST_ISSUE);
  assign p_s32     = 64'(prod >>> 32);
  assign p_s16     = 64'(prod >>> 16);

  smo_pll_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // Result fields from the updated state
  logic [31:0]        angle_sh;
  logic signed [23:0] lpa_sh, lpb_sh;
  logic [15:0]        emf_a_out, emf_b_out;

  always_comb begin
    angle_sh = angle_q >> (32 - ANGLE_BITS);
    lpa_sh   = 24'(lp_a_q >>> 8);
    lpb_sh   = 24'(lp_b_q >>> 8);
    if (lpa_sh > 24'sd32767) emf_a_out = 16'h7fff;
    else if (lpa_sh < -24'sd32768) emf_a_out = 16'h8000;
    else emf_a_out = 16'(lpa_sh);
    if (lpb_sh > 24'sd32767) emf_b_out = 16'h7fff;
    else if (lpb_sh < -24'sd32768) emf_b_out = 16'h8000;
    else emf_b_out = 16'(lpb_sh);
  end

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q <= smo_pll_pkg::SamplePeriodRst;
      h_q  <= smo_pll_pkg::SlideGainRst;
      kp_q <= smo_pll_pkg::PropGainRst;
      ki_q <= smo_pll_pkg::IntGainRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        smo_pll_pkg::REG_SAMPLE_PERIOD: ts_q <= cfg_data_i;
        smo_pll_pkg::REG_SLIDE_GAIN:    h_q  <= cfg_data_i[15:0];
        smo_pll_pkg::REG_PLL_PROP_GAIN: kp_q <= cfg_data_i;
        smo_pll_pkg::REG_PLL_INT_GAIN:  ki_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Sequencer: step through the products and fold each into the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_SIN_UQ;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      ia_q        <= '0;
      ib_q        <= '0;
      uq_q        <= '0;
      obs_a_q     <= '0;
      obs_b_q     <= '0;
      emf_a_q     <= '0;
      emf_b_q     <= '0;
      lp_a_q      <= '0;
      lp_b_q      <= '0;
      integ_q     <= '0;
      speed_lp_q  <= '0;
      speed_q     <= '0;
      ua_q        <= '0;
      ub_q        <= '0;
      err_q       <= '0;
      tmp_q       <= '0;
      angle_q     <= '0;
    end else begin
      // Drop the result once taken, unless a new one is loaded this cycle
      if (out_valid_q && m_axis_tready && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            ia_q    <= s_axis_tdata[15:0];
            ib_q    <= s_axis_tdata[31:16];
            uq_q    <= s_axis_tdata[47:32];
            op_q    <= OP_SIN_UQ;
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (mul_done) begin
            unique case (op_q)
              OP_SIN_UQ: ua_q <= 32'((-prod) >>> 7);
              OP_COS_UQ: ub_q <= 32'(prod >>> 7);
              OP_OBS_A, OP_OBS_B, OP_LPO_A, OP_LPO_B, OP_ERR_C, OP_SPO:
                tmp_q <= 64'(prod);
              OP_DIF_A, OP_DIF_B: tmp_q <= tmp_q + 64'(prod);
              OP_INT_A:  obs_a_q <= smo_pll_pkg::sat32(64'(obs_a_q) + p_s32);
              OP_INT_B:  obs_b_q <= smo_pll_pkg::sat32(64'(obs_b_q) + p_s32);
              OP_EMF_A:  emf_a_q <= smo_pll_pkg::sat32(64'(prod >>> 8));
              OP_EMF_B:  emf_b_q <= smo_pll_pkg::sat32(64'(prod >>> 8));
              OP_LPN_A:  lp_a_q <= smo_pll_pkg::sat32((tmp_q + 64'(prod) + 64'sd32768) >>> 16);
              OP_LPN_B:  lp_b_q <= smo_pll_pkg::sat32((tmp_q + 64'(prod) + 64'sd32768) >>> 16);
              OP_ERR_S:  err_q <= 34'(-((tmp_q + 64'(prod)) >>> 15));
              OP_KI:     tmp_q <= p_s16;
              OP_TS_I:   integ_q <= smo_pll_pkg::sat32(64'(integ_q) + p_s32);
              OP_KP:     speed_q <= smo_pll_pkg::sat32(p_s16 + 64'(integ_q));
              OP_SPN:    speed_lp_q <= smo_pll_pkg::sat32((tmp_q + 64'(prod) + 64'sd32768) >>> 16);
              OP_RAD:    tmp_q <= p_s32;
              OP_ANG:    angle_q <= angle_q + p_s32[31:0];
              default: ;
            endcase
            if (op_q == OP_ANG) begin
              state_q <= ST_DONE;
            end else begin
              op_q    <= op_e'(op_q + 5'd1);
              state_q <= ST_ISSUE;
            end
          end
        end
        ST_DONE: begin
          // Hold until the output register is free
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {emf_b_out, emf_a_out, speed_lp_q, angle_sh[15:0]};
            op_q        <= OP_SIN_UQ;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Checks
  a_idle_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> op_q == OP_SIN_UQ)
    else $error("sequencer idle away from first step");

  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == ST_WAIT)
    else $error("product finished outside wait state");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item taken while another is in work");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == ST_DONE)
    else $error("result shown without finishing an item");

endmodule
